### rtl/ghd_pkg.sv
// ----------------------------------------------------------------------------
// ghd_pkg
// Shared types and constants of the grid heat diffusion sweep block.
// ----------------------------------------------------------------------------
package ghd_pkg;

    // default store geometry
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // field widths
    localparam int TEMP_W = 24;
    localparam int COEF_W = 9;
    localparam int CELL_W = TEMP_W + 2 * COEF_W;
    localparam int IN_W   = 64;
    localparam int CFG_IW = 8;

    // request codes
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_SWEEP = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    // register indexes
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 8'd0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 8'd1;

    // sweep steps within one cell
    localparam logic [2:0] PH_CENTRE = 3'd0;
    localparam logic [2:0] PH_LEFT   = 3'd1;
    localparam logic [2:0] PH_RIGHT  = 3'd2;
    localparam logic [2:0] PH_UP     = 3'd3;
    localparam logic [2:0] PH_DOWN   = 3'd4;
    localparam logic [2:0] PH_LAST_N = 3'd5;
    localparam logic [2:0] PH_MUL    = 3'd6;
    localparam logic [2:0] PH_WRITE  = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP
    } state_t;

endpackage

### rtl/ghd_ram.sv
// ----------------------------------------------------------------------------
// ghd_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ghd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/grid_heat_diffusion_sweep_top.sv
// ----------------------------------------------------------------------------
// grid_heat_diffusion_sweep_top
// In-place raster diffusion sweep over a grid of cells held in one RAM.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: load a cell, run one sweep, or read a
// cell temperature. A load gives no result. A read gives one result on the
// m_ stream, from the registered RAM read or, if the address lies outside
// the store, straight into the output register. A sweep walks the in-use
// grid in raster order; the single RAM read port fetches each cell and its
// four neighbours in turn, followed by the multiply and the write back.
// A sweep ends with one result carrying tuser = 1. Grid size must be written
// by the user on the cfg channel while no request is in progress; the block
// itself does not enforce it.
// Reset restores a 256 by 256 grid and empties the output register; cell
// contents are kept undefined until loaded.
// When the receiver stalls, the result waits in the output register and no
// further request is taken until it has been accepted.
// ----------------------------------------------------------------------------
module grid_heat_diffusion_sweep_top #(
    parameter int MAX_WIDTH  = ghd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = ghd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // col[7:0], row[15:8], temperature_in[39:16],
    // conductivity_in[48:40], capacity_in[57:49], zero fill
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ghd_pkg::IN_W-1:0]    s_tdata,
    // action[1:0]
    input  logic [1:0]                  s_tuser,
    // temperature_out[23:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ghd_pkg::TEMP_W-1:0]  m_tdata,
    // sweep_done[0]
    output logic                        m_tuser,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ghd_pkg::CFG_IW-1:0]  cfg_index,
    input  logic [8:0]                  cfg_data
);

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int CWX   = $clog2(MAX_WIDTH + 1);
    localparam int CWY   = $clog2(MAX_HEIGHT + 1);
    localparam int TW    = ghd_pkg::TEMP_W;
    localparam int KW    = ghd_pkg::COEF_W;

    // input fields
    logic [1:0]    in_action;
    logic [7:0]    in_col;
    logic [7:0]    in_row;
    logic [TW-1:0] in_temp;
    logic [KW-1:0] in_cond;
    logic [KW-1:0] in_cap;
    logic          in_inside;
    logic [AW-1:0] in_addr;
    logic          s_fire;

    assign in_action = s_tuser;
    assign in_col    = s_tdata[7:0];
    assign in_row    = s_tdata[15:8];
    assign in_temp   = s_tdata[39:16];
    assign in_cond   = s_tdata[48:40];
    assign in_cap    = s_tdata[57:49];
    assign in_inside = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
    assign in_addr   = AW'(32'(in_row) * MAX_WIDTH + 32'(in_col));
    assign s_fire    = s_tvalid && s_tready;

    // configuration registers
    logic [8:0] grid_width_reg;
    logic [8:0] grid_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= 9'd256;
            grid_height_reg <= 9'd256;
        end else if (cfg_valid) begin
            if (cfg_index == ghd_pkg::REG_WIDTH) begin
                grid_width_reg <= cfg_data;
            end
            if (cfg_index == ghd_pkg::REG_HEIGHT) begin
                grid_height_reg <= cfg_data;
            end
        end
    end

    // effective grid size, zero acts as one, clamped to the store
    logic [CWX-1:0] w_eff;
    logic [CWY-1:0] h_eff;

    always_comb begin
        if (grid_width_reg == 9'd0) begin
            w_eff = CWX'(1);
        end else if (32'(grid_width_reg) > MAX_WIDTH) begin
            w_eff = CWX'(MAX_WIDTH);
        end else begin
            w_eff = CWX'(grid_width_reg);
        end
        if (grid_height_reg == 9'd0) begin
            h_eff = CWY'(1);
        end else if (32'(grid_height_reg) > MAX_HEIGHT) begin
            h_eff = CWY'(MAX_HEIGHT);
        end else begin
            h_eff = CWY'(grid_height_reg);
        end
    end

    // state
    ghd_pkg::state_t state_reg, state_next;
    logic [2:0]      ph_reg;
    logic [XW-1:0]   x_reg;
    logic [YW-1:0]   y_reg;
    logic [AW-1:0]   base_reg;
    logic            m_valid_reg;
    logic [TW-1:0]   m_data_reg;
    logic            m_user_reg;

    // cell datapath registers
    logic [TW-1:0]          tc_reg;
    logic [KW-1:0]          kc_reg;
    logic [KW-1:0]          cc_reg;
    logic signed [36:0]     acc_reg;
    logic signed [47:0]     prod_reg;

    logic            out_free;
    logic            x_last;
    logic            y_last;
    logic            cell_last;

    assign out_free  = !m_valid_reg || m_tready;
    assign x_last    = (CWX'(x_reg) + CWX'(1)) == w_eff;
    assign y_last    = (CWY'(y_reg) + CWY'(1)) == h_eff;
    assign cell_last = x_last && y_last;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ghd_pkg::ST_IDLE: begin
                if (s_fire && in_action == ghd_pkg::ACT_SWEEP) begin
                    state_next = ghd_pkg::ST_SWEEP;
                end else if (s_fire && in_action == ghd_pkg::ACT_READ && in_inside) begin
                    state_next = ghd_pkg::ST_READ;
                end
            end
            ghd_pkg::ST_READ: begin
                state_next = ghd_pkg::ST_IDLE;
            end
            ghd_pkg::ST_SWEEP: begin
                if (ph_reg == ghd_pkg::PH_WRITE && cell_last) begin
                    state_next = ghd_pkg::ST_IDLE;
                end
            end
            default: state_next = ghd_pkg::ST_IDLE;
        endcase
    end

    // ram and handshake controls
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ghd_pkg::CELL_W-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [ghd_pkg::CELL_W-1:0] ram_rdata;
    logic [AW-1:0]          c_addr;
    logic [TW-1:0]          t_new;
    logic                   out_load;
    logic [TW-1:0]          out_data;
    logic                   out_user;

    assign c_addr = base_reg + AW'(x_reg);

    always_comb begin
        s_tready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = in_addr;
        ram_wdata = {in_cap, in_cond, in_temp};
        ram_raddr = in_addr;
        out_load  = 1'b0;
        out_data  = '0;
        out_user  = 1'b0;
        unique case (state_reg)
            ghd_pkg::ST_IDLE: begin
                s_tready = out_free;
                if (s_fire && in_action == ghd_pkg::ACT_LOAD && in_inside) begin
                    ram_we = 1'b1;
                end
                if (s_fire && in_action == ghd_pkg::ACT_READ && !in_inside) begin
                    out_load = 1'b1;
                end
            end
            ghd_pkg::ST_READ: begin
                out_load = 1'b1;
                out_data = ram_rdata[TW-1:0];
            end
            ghd_pkg::ST_SWEEP: begin
                unique case (ph_reg)
                    ghd_pkg::PH_CENTRE: ram_raddr = c_addr;
                    ghd_pkg::PH_LEFT:   ram_raddr = c_addr - AW'(1);
                    ghd_pkg::PH_RIGHT:  ram_raddr = c_addr + AW'(1);
                    ghd_pkg::PH_UP:     ram_raddr = c_addr - AW'(MAX_WIDTH);
                    ghd_pkg::PH_DOWN:   ram_raddr = c_addr + AW'(MAX_WIDTH);
                    default:            ram_raddr = c_addr;
                endcase
                ram_waddr = c_addr;
                ram_wdata = {cc_reg, kc_reg, t_new};
                if (ph_reg == ghd_pkg::PH_WRITE) begin
                    ram_we = 1'b1;
                    if (cell_last) begin
                        out_load = 1'b1;
                        out_user = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // neighbour term for the entry now on the read port
    logic [KW-1:0]      kn;
    logic [KW-1:0]      kmin;
    logic signed [24:0] diff;
    logic signed [34:0] term;
    logic               nb_valid;
    logic signed [10:0] fac;
    logic signed [29:0] flow;
    logic signed [30:0] t_sum;

    assign kn   = ram_rdata[TW+KW-1:TW];
    assign kmin = (kn < kc_reg) ? kn : kc_reg;
    assign diff = $signed({1'b0, ram_rdata[TW-1:0]}) - $signed({1'b0, tc_reg});
    assign term = diff * $signed({1'b0, kmin});
    assign fac  = $signed(11'd256) - $signed({2'b00, cc_reg});
    assign flow = prod_reg[47:18];
    assign t_sum = $signed({7'b0, tc_reg}) + 31'(flow);

    always_comb begin
        unique case (ph_reg)
            ghd_pkg::PH_RIGHT:  nb_valid = (x_reg != '0);
            ghd_pkg::PH_UP:     nb_valid = !x_last;
            ghd_pkg::PH_DOWN:   nb_valid = (y_reg != '0);
            ghd_pkg::PH_LAST_N: nb_valid = !y_last;
            default:            nb_valid = 1'b0;
        endcase
    end

    // clamp at zero, saturate at the top of the range
    always_comb begin
        if (t_sum < 0) begin
            t_new = '0;
        end else if (t_sum > $signed(31'h00FF_FFFF)) begin
            t_new = '1;
        end else begin
            t_new = t_sum[TW-1:0];
        end
    end

    // state and sweep counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ghd_pkg::ST_IDLE;
            ph_reg    <= ghd_pkg::PH_CENTRE;
            x_reg     <= '0;
            y_reg     <= '0;
            base_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ghd_pkg::ST_IDLE) begin
                ph_reg   <= ghd_pkg::PH_CENTRE;
                x_reg    <= '0;
                y_reg    <= '0;
                base_reg <= '0;
            end else if (state_reg == ghd_pkg::ST_SWEEP) begin
                ph_reg <= ph_reg + 3'd1;
                if (ph_reg == ghd_pkg::PH_WRITE) begin
                    if (x_last) begin
                        x_reg    <= '0;
                        y_reg    <= y_reg + YW'(1);
                        base_reg <= base_reg + AW'(MAX_WIDTH);
                    end else begin
                        x_reg <= x_reg + XW'(1);
                    end
                end
            end
        end
    end

    // cell datapath
    always_ff @(posedge aclk) begin
        if (state_reg == ghd_pkg::ST_SWEEP) begin
            if (ph_reg == ghd_pkg::PH_LEFT) begin
                tc_reg  <= ram_rdata[TW-1:0];
                kc_reg  <= ram_rdata[TW+KW-1:TW];
                cc_reg  <= ram_rdata[TW+2*KW-1:TW+KW];
                acc_reg <= '0;
            end else if (nb_valid) begin
                acc_reg <= acc_reg + 37'(term);
            end
            if (ph_reg == ghd_pkg::PH_MUL) begin
                prod_reg <= acc_reg * fac;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_data;
            m_user_reg <= out_user;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // cell store: temperature, conductivity, capacity
    ghd_ram #(
        .WIDTH (ghd_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule
